>>> rtl/core/gpd_pkg.sv
// Shared types and constants for the gamepad packet deframer.
package gpd_pkg;

	localparam int unsigned FRAME_LEN = 11;
	localparam int unsigned CNT_W = 4;
	localparam int unsigned CFG_IDX_W = 3;
	localparam int unsigned QUEUE_DEPTH = 2;

	localparam logic [CNT_W-1:0] CNT_HUNT = 4'd0;
	localparam logic [CNT_W-1:0] CNT_LAST = CNT_W'(FRAME_LEN - 1);

	localparam logic [1:0] ST_OK  = 2'd0;
	localparam logic [1:0] ST_HDR = 2'd1;
	localparam logic [1:0] ST_SUM = 2'd2;

	localparam logic [CFG_IDX_W-1:0] REG_SYNC_FIRST  = 3'd0;
	localparam logic [CFG_IDX_W-1:0] REG_SYNC_SECOND = 3'd1;
	localparam logic [CFG_IDX_W-1:0] REG_DEAD_ZONE   = 3'd2;
	localparam logic [CFG_IDX_W-1:0] REG_STICK_LIMIT = 3'd3;
	localparam logic [CFG_IDX_W-1:0] REG_TRIG_LIMIT  = 3'd4;

	typedef struct packed {
		logic [7:0] sync_first;
		logic [7:0] sync_second;
		logic [6:0] dead_zone;
		logic [6:0] stick_limit;
		logic [7:0] trig_limit;
	} cfg_t;

	typedef struct packed {
		logic [1:0]      status;
		logic [3:0][7:0] stick;
		logic [1:0][7:0] trig;
		logic [3:0]      btn;
	} frame_t;

endpackage

>>> rtl/core/gpd_front.sv
// Byte collector: header hunt, frame capture, running checksum and frame check.
module gpd_front
	import gpd_pkg::*;
(
	input  logic       clk,
	input  logic       arst_n,
	input  cfg_t       cfg,
	input  logic       in_valid,
	output logic       in_stall,
	input  logic [7:0] rx_byte,
	input  logic       q_full,
	output logic       push,
	output frame_t     push_data
);

	logic [CNT_W-1:0] cnt_q;
	logic [7:0]       sum_q;
	logic [7:0]       hdr_q;
	logic [3:0][7:0]  stick_q;
	logic [1:0][7:0]  trig_q;
	logic [3:0]       btn_q;
	logic             accept;

	assign in_stall = q_full;
	assign accept   = in_valid && !q_full;
	assign push     = accept && (cnt_q == CNT_LAST);

	always_comb begin
		push_data.stick = stick_q;
		push_data.trig  = trig_q;
		push_data.btn   = btn_q;
		if (hdr_q != cfg.sync_second) begin
			push_data.status = ST_HDR;
		end else if (sum_q != rx_byte) begin
			push_data.status = ST_SUM;
		end else begin
			push_data.status = ST_OK;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cnt_q <= CNT_HUNT;
		end else if (accept) begin
			if (cnt_q == CNT_HUNT) begin
				if (rx_byte == cfg.sync_first) begin
					cnt_q <= cnt_q + 4'd1;
				end
			end else if (cnt_q == CNT_LAST) begin
				cnt_q <= CNT_HUNT;
			end else begin
				cnt_q <= cnt_q + 4'd1;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			if (cnt_q == CNT_HUNT) begin
				sum_q <= rx_byte;
			end else begin
				sum_q <= sum_q + rx_byte;
			end
			case (cnt_q)
				4'd1: hdr_q <= rx_byte;
				4'd2, 4'd3, 4'd4, 4'd5: stick_q[cnt_q[1:0] - 2'd2] <= rx_byte;
				4'd6, 4'd7: trig_q[cnt_q[0]] <= rx_byte;
				4'd8: btn_q <= rx_byte[3:0];
				default: ;
			endcase
		end
	end

	a_cnt_range: assert property (@(posedge clk) disable iff (!arst_n)
		cnt_q <= CNT_LAST)
		else $error("byte count beyond frame length");

	a_push_hunt: assert property (@(posedge clk) disable iff (!arst_n)
		push |=> cnt_q == CNT_HUNT)
		else $error("frame end did not return to hunt");

endmodule

>>> rtl/core/gpd_queue.sv
// Two-entry queue of checked frames between collector and decoder.
module gpd_queue
	import gpd_pkg::*;
(
	input  logic   clk,
	input  logic   arst_n,
	input  logic   push,
	input  frame_t din,
	output logic   full,
	input  logic   pop,
	output frame_t dout,
	output logic   empty
);

	frame_t     mem_q [QUEUE_DEPTH];
	logic       wr_ptr_q;
	logic       rd_ptr_q;
	logic [1:0] count_q;

	assign full  = (count_q == 2'(QUEUE_DEPTH));
	assign empty = (count_q == 2'd0);
	assign dout  = mem_q[rd_ptr_q];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= 1'b0;
			rd_ptr_q <= 1'b0;
			count_q  <= 2'd0;
		end else begin
			if (push) begin
				wr_ptr_q <= ~wr_ptr_q;
			end
			if (pop) begin
				rd_ptr_q <= ~rd_ptr_q;
			end
			if (push && !pop) begin
				count_q <= count_q + 2'd1;
			end else if (pop && !push) begin
				count_q <= count_q - 2'd1;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (push) begin
			mem_q[wr_ptr_q] <= din;
		end
	end

	a_no_overflow: assert property (@(posedge clk) disable iff (!arst_n)
		push |-> !full)
		else $error("push into full queue");

	a_no_underflow: assert property (@(posedge clk) disable iff (!arst_n)
		pop |-> !empty)
		else $error("pop from empty queue");

	a_count_range: assert property (@(posedge clk) disable iff (!arst_n)
		count_q <= 2'(QUEUE_DEPTH))
		else $error("queue count out of range");

endmodule

>>> rtl/core/gpd_back.sv
// Decoder: applies dead zone and clamps, holds controller values, drives results.
module gpd_back
	import gpd_pkg::*;
(
	input  logic       clk,
	input  logic       arst_n,
	input  cfg_t       cfg,
	input  logic       q_empty,
	input  frame_t     q_data,
	output logic       pop,
	output logic       out_valid,
	input  logic       out_stall,
	output logic [1:0] frame_status,
	output logic [3:0][7:0] sticks,
	output logic [1:0][7:0] trigs,
	output logic [3:0] btns
);

	logic            out_valid_q;
	logic [1:0]      status_q;
	logic [3:0][7:0] stick_q;
	logic [1:0][7:0] trig_q;
	logic [3:0]      btn_q;
	logic [3:0][7:0] stick_dec;
	logic [1:0][7:0] trig_dec;

	function automatic logic [7:0] decode_stick(input logic [7:0] raw,
		input logic [6:0] dz, input logic [6:0] lim);
		logic signed [8:0] c;
		logic [7:0]        mag;
		logic signed [8:0] lim_s;
		c     = $signed({~raw[7], ~raw[7], raw[6:0]});
		mag   = c[8] ? 8'(-c) : c[7:0];
		lim_s = $signed({2'b00, lim});
		if (mag < {1'b0, dz}) begin
			c = 9'sd0;
		end
		if (c > lim_s) begin
			c = lim_s;
		end else if (c < -lim_s) begin
			c = -lim_s;
		end
		return c[7:0];
	endfunction

	always_comb begin
		for (int i = 0; i < 4; i++) begin
			stick_dec[i] = decode_stick(q_data.stick[i], cfg.dead_zone, cfg.stick_limit);
		end
		for (int i = 0; i < 2; i++) begin
			trig_dec[i] = (q_data.trig[i] > cfg.trig_limit) ? cfg.trig_limit : q_data.trig[i];
		end
	end

	assign pop          = !q_empty && (!out_valid_q || !out_stall);
	assign out_valid    = out_valid_q;
	assign frame_status = status_q;
	assign sticks       = stick_q;
	assign trigs        = trig_q;
	assign btns         = btn_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
			status_q    <= ST_OK;
			stick_q     <= '0;
			trig_q      <= '0;
			btn_q       <= '0;
		end else begin
			if (pop) begin
				out_valid_q <= 1'b1;
				status_q    <= q_data.status;
				if (q_data.status == ST_OK) begin
					stick_q <= stick_dec;
					trig_q  <= trig_dec;
					btn_q   <= q_data.btn;
				end
			end else if (!out_stall) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	a_held_on_reject: assert property (@(posedge clk) disable iff (!arst_n)
		pop && (q_data.status != ST_OK) |=> $stable(stick_q) && $stable(trig_q))
		else $error("held values changed on rejected frame");

endmodule

>>> rtl/core/gamepad_packet_deframer_top.sv
// Top level of the gamepad packet deframer.
// Takes one received byte per cycle while in_stall is low. Bytes are dropped until the first header byte
// arrives; then eleven bytes form a frame, closed by an 8-bit additive checksum.
// Each frame end gives one result through the frame queue and the output registers: a status (accepted,
// second header wrong, checksum wrong) and the held stick, trigger and button values,
// which change only on accepted frames. A two-entry frame queue sits between the byte
// collector and the decoder, so bytes keep flowing while a result waits; in_stall
// rises only when that queue is full. Configuration is written through cfg_valid,
// which is always ready, and should be changed only while no frame is in flight.
module gamepad_packet_deframer_top
	import gpd_pkg::*;
(
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic                 cfg_valid,
	output logic                 cfg_ready,
	input  logic [CFG_IDX_W-1:0] cfg_index,
	input  logic [7:0]           cfg_data,
	input  logic                 in_valid,
	output logic                 in_stall,
	input  logic [7:0]           rx_byte,
	output logic                 out_valid,
	input  logic                 out_stall,
	output logic [1:0]           frame_status,
	output logic signed [7:0]    left_x,
	output logic signed [7:0]    left_y,
	output logic signed [7:0]    right_x,
	output logic signed [7:0]    right_y,
	output logic [7:0]           left_trig,
	output logic [7:0]           right_trig,
	output logic                 button_a,
	output logic                 bumper_left,
	output logic                 bumper_right,
	output logic                 button_start
);

	cfg_t            cfg_q;
	logic            q_full;
	logic            q_empty;
	logic            push;
	logic            pop;
	frame_t          push_data;
	frame_t          pop_data;
	logic [3:0][7:0] sticks;
	logic [1:0][7:0] trigs;
	logic [3:0]      btns;

	assign cfg_ready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.sync_first  <= 8'd7;
			cfg_q.sync_second <= 8'd33;
			cfg_q.dead_zone   <= 7'd5;
			cfg_q.stick_limit <= 7'd100;
			cfg_q.trig_limit  <= 8'd100;
		end else if (cfg_valid && cfg_ready) begin
			case (cfg_index)
				REG_SYNC_FIRST:  cfg_q.sync_first  <= cfg_data;
				REG_SYNC_SECOND: cfg_q.sync_second <= cfg_data;
				REG_DEAD_ZONE:   cfg_q.dead_zone   <= cfg_data[6:0];
				REG_STICK_LIMIT: cfg_q.stick_limit <= cfg_data[6:0];
				REG_TRIG_LIMIT:  cfg_q.trig_limit  <= cfg_data;
				default: ;
			endcase
		end
	end

	gpd_front u_front (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg       (cfg_q),
		.in_valid  (in_valid),
		.in_stall  (in_stall),
		.rx_byte   (rx_byte),
		.q_full    (q_full),
		.push      (push),
		.push_data (push_data)
	);

	gpd_queue u_queue (
		.clk    (clk),
		.arst_n (arst_n),
		.push   (push),
		.din    (push_data),
		.full   (q_full),
		.pop    (pop),
		.dout   (pop_data),
		.empty  (q_empty)
	);

	gpd_back u_back (
		.clk          (clk),
		.arst_n       (arst_n),
		.cfg          (cfg_q),
		.q_empty      (q_empty),
		.q_data       (pop_data),
		.pop          (pop),
		.out_valid    (out_valid),
		.out_stall    (out_stall),
		.frame_status (frame_status),
		.sticks       (sticks),
		.trigs        (trigs),
		.btns         (btns)
	);

	assign left_x       = sticks[0];
	assign left_y       = sticks[1];
	assign right_x      = sticks[2];
	assign right_y      = sticks[3];
	assign left_trig    = trigs[0];
	assign right_trig   = trigs[1];
	assign button_a     = btns[0];
	assign bumper_left  = btns[1];
	assign bumper_right = btns[2];
	assign button_start = btns[3];

endmodule
